// File: design/oaht_pkg.sv
// Shared types, codes and field widths of the open-addressed hash table.
`default_nettype none
package oaht_pkg;

  localparam int CMD_W  = 2;
  localparam int KEY_W  = 32;
  localparam int HASH_W = 32;
  localparam int VAL_W  = 64;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 9;
  localparam int MARK_W = 2;

  localparam logic [CNT_W-1:0] FILL_LIMIT_RST = 9'd192;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [MARK_W-1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_WRITE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic step;
    logic fin;
    logic write;
    logic push;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic probe_done;
    logic need_write;
  } ctl_sts_t;

endpackage
`default_nettype wire

// File: design/oaht_if.sv
// Request, response and configuration channel interfaces.
`default_nettype none
interface oaht_req_if import oaht_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [KEY_W-1:0]  key;
  logic [HASH_W-1:0] key_hash;
  logic [VAL_W-1:0]  new_value;
  modport source (output valid, command, key, key_hash, new_value, input ready);
  modport sink (input valid, command, key, key_hash, new_value, output ready);
endinterface

interface oaht_rsp_if import oaht_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              is_new;
  logic [VAL_W-1:0]  value_out;
  modport source (output valid, status, is_new, value_out, input ready);
  modport sink (input valid, status, is_new, value_out, output ready);
endinterface

interface oaht_cfg_if import oaht_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] fill_limit;
  modport source (output valid, fill_limit, input ready);
  modport sink (input valid, fill_limit, output ready);
endinterface
`default_nettype wire

// File: design/oaht_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/oaht_ctrl.sv
// Controller state machine of the hash table: clearing, probing, write-back, response.
`default_nettype none
module oaht_ctrl import oaht_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire ctl_sts_t sts,
  output ctl_cmd_t      cmd,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready
);

  state_e state;
  state_e state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts.probe_done) begin
          cmd.fin    = 1'b1;
          state_next = sts.need_write ? S_WRITE : S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
    out_valid_next = cmd.push || (out_valid && !out_ready);
  end

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!out_valid || out_ready))
    else $error("Response pushed over an untaken response.");

  a_write_after_fin: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> $past(cmd.fin))
    else $error("Slot write without a finished probe.");

  a_accept_probes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_PROBE && !in_ready))
    else $error("Accepted request did not start a probe.");

endmodule
`default_nettype wire

// File: design/oaht_dp.sv
// Datapath of the hash table: slot memory, probe registers, fill count and result registers.
`default_nettype none
module oaht_dp import oaht_pkg::*; #(
  parameter int CAPACITY   = 256,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctl_cmd_t          cmd,
  output ctl_sts_t               sts,
  input  wire logic [CMD_W-1:0]  command,
  input  wire logic [KEY_W-1:0]  key,
  input  wire logic [HASH_W-1:0] key_hash,
  input  wire logic [VAL_W-1:0]  new_value,
  input  wire logic              cfg_we,
  input  wire logic [CNT_W-1:0]  cfg_data,
  output logic [STAT_W-1:0]      status,
  output logic                   is_new,
  output logic [VAL_W-1:0]       value_out
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int ENT_W = MARK_W + KEY_BITS + VALUE_BITS;

  logic [CMD_W-1:0]      req_cmd;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_val;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      probe_n;
  logic                  have_tomb;
  logic [IDX_W-1:0]      tomb_idx;
  logic [IDX_W-1:0]      clr_idx;
  logic [CNT_W-1:0]      fill_count;
  logic [CNT_W-1:0]      fill_limit;
  logic [IDX_W-1:0]      wr_slot;
  logic [ENT_W-1:0]      wr_data;
  logic [STAT_W-1:0]     res_status;
  logic                  res_is_new;
  logic [VALUE_BITS-1:0] res_value;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ENT_W-1:0]      ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [ENT_W-1:0]      rdata;

  logic [MARK_W-1:0]     rd_mark;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  cur_empty;
  logic                  cur_tomb;
  logic                  cur_hit;
  logic                  early_miss;
  logic                  tomb_any;
  logic [IDX_W-1:0]      tomb_slot;
  logic [CNT_W:0]        fill_plus;
  logic                  over_limit;

  status_e               fin_status;
  logic                  fin_new;
  logic [VALUE_BITS-1:0] fin_value;
  logic                  fin_write;
  logic [IDX_W-1:0]      fin_slot;
  mark_e                 fin_mark;
  logic [VALUE_BITS-1:0] fin_entval;
  logic                  fin_inc;

  oaht_ram #(
    .WIDTH(ENT_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  assign ram_we    = cmd.clear || cmd.write;
  assign ram_waddr = cmd.clear ? clr_idx : wr_slot;
  assign ram_wdata = cmd.clear ? {MARK_EMPTY, {(ENT_W-MARK_W){1'b0}}} : wr_data;
  assign ram_raddr = cmd.load ? key_hash[IDX_W-1:0] : IDX_W'(idx + 1'b1);

  assign rd_mark   = rdata[ENT_W-1 -: MARK_W];
  assign rd_key    = rdata[VALUE_BITS +: KEY_BITS];
  assign rd_val    = rdata[VALUE_BITS-1:0];
  assign cur_empty = (rd_mark == MARK_EMPTY);
  assign cur_tomb  = (rd_mark == MARK_TOMB);
  assign cur_hit   = (rd_mark == MARK_LIVE) && (rd_key == req_key);
  assign tomb_any  = have_tomb || cur_tomb;
  assign tomb_slot = have_tomb ? tomb_idx : idx;
  assign fill_plus = {1'b0, fill_count} + (CNT_W+1)'(1);
  assign over_limit = fill_plus > {1'b0, fill_limit};

  always_comb begin
    unique case (req_cmd)
      CMD_INSERT: early_miss = 1'b0;
      CMD_LOOKUP,
      CMD_REMOVE: early_miss = (fill_count == '0);
      default:    early_miss = 1'b1;
    endcase
  end

  assign sts.clear_last = &clr_idx;
  assign sts.probe_done = early_miss || cur_empty || cur_hit || (&probe_n);
  assign sts.need_write = fin_write;

  always_comb begin
    fin_status = ST_MISS;
    fin_new    = 1'b0;
    fin_value  = '0;
    fin_write  = 1'b0;
    fin_slot   = idx;
    fin_mark   = MARK_LIVE;
    fin_entval = req_val;
    fin_inc    = 1'b0;
    if (!early_miss) begin
      unique case (req_cmd)
        CMD_LOOKUP: begin
          if (cur_hit) begin
            fin_status = ST_OK;
            fin_value  = rd_val;
          end
        end
        CMD_INSERT: begin
          priority if (cur_hit) begin
            fin_status = ST_OK;
            fin_write  = 1'b1;
          end else if (tomb_any) begin
            fin_status = ST_OK;
            fin_new    = 1'b1;
            fin_write  = 1'b1;
            fin_slot   = tomb_slot;
          end else if (cur_empty && !over_limit) begin
            fin_status = ST_OK;
            fin_new    = 1'b1;
            fin_write  = 1'b1;
            fin_inc    = 1'b1;
          end else begin
            fin_status = ST_FULL;
          end
        end
        CMD_REMOVE: begin
          if (cur_hit) begin
            fin_status = ST_OK;
            fin_write  = 1'b1;
            fin_mark   = MARK_TOMB;
            fin_entval = rd_val;
          end
        end
        default: begin
          fin_status = ST_MISS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      fill_count <= '0;
      fill_limit <= FILL_LIMIT_RST;
    end else begin
      if (cmd.clear) begin
        clr_idx <= IDX_W'(clr_idx + 1'b1);
      end
      if (cmd.fin && fin_inc) begin
        fill_count <= fill_plus[CNT_W-1:0];
      end
      if (cfg_we) begin
        fill_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd   <= command;
      req_key   <= KEY_BITS'(key);
      req_val   <= VALUE_BITS'(new_value);
      idx       <= key_hash[IDX_W-1:0];
      probe_n   <= '0;
      have_tomb <= 1'b0;
    end else if (cmd.step) begin
      idx     <= IDX_W'(idx + 1'b1);
      probe_n <= IDX_W'(probe_n + 1'b1);
      if (cur_tomb && !have_tomb) begin
        have_tomb <= 1'b1;
        tomb_idx  <= idx;
      end
    end
    if (cmd.fin) begin
      res_status <= fin_status;
      res_is_new <= fin_new;
      res_value  <= fin_value;
      wr_slot    <= fin_slot;
      wr_data    <= {fin_mark, req_key, fin_entval};
    end
    if (cmd.push) begin
      status    <= res_status;
      is_new    <= res_is_new;
      value_out <= VAL_W'(res_value);
    end
  end

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && fill_count != $past(fill_count)) |->
      ($past(cmd.fin) && fill_count == CNT_W'($past(fill_count) + 1'b1)))
    else $error("Fill count moved other than by one on a finished insert.");

  a_write_mark: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> (wr_data[ENT_W-1 -: MARK_W] != MARK_EMPTY))
    else $error("Slot write would leave an empty mark.");

  a_one_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !(&probe_n))
    else $error("Probe ran past one full sweep.");

endmodule
`default_nettype wire

// File: design/open_addressing_hash_table.sv
// Top level of the open-addressed hash table with linear probing and tombstones.
//
//   Channel  Role    Payload
//   req      sink    command, key, key_hash, new_value
//   rsp      source  status, is_new, value_out
//   cfg      sink    fill_limit (always ready)
//
// After reset every slot mark is cleared to empty; no request is taken meanwhile.
// A request probes P consecutive slots from its hash, wrapping, P being 1 to CAPACITY.
// A request that stores or removes a key passes through the slot write state before its response.
// The single slot memory, read once per cycle, sets the probe rate.
// A finished response waits in the output register while the next request is taken.
`default_nettype none
module open_addressing_hash_table import oaht_pkg::*; #(
  parameter int CAPACITY   = 256,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 64
) (
  input wire logic clk,
  input wire logic rst,
  oaht_req_if.sink   req,
  oaht_rsp_if.source rsp,
  oaht_cfg_if.sink   cfg
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg.ready = 1'b1;

  oaht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .sts      (sts),
    .cmd      (cmd),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready)
  );

  oaht_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .command  (req.command),
    .key      (req.key),
    .key_hash (req.key_hash),
    .new_value(req.new_value),
    .cfg_we   (cfg.valid),
    .cfg_data (cfg.fill_limit),
    .status   (rsp.status),
    .is_new   (rsp.is_new),
    .value_out(rsp.value_out)
  );

endmodule
`default_nettype wire

// File: dv/tb_open_addressing_hash_table.sv
// Self-checking testbench: random and directed table requests against an in-bench table predictor.
module tb_open_addressing_hash_table import oaht_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 256;
  localparam int POOL = 48;
  localparam int RECENT = 32;
  localparam int SETTLE = 4;
  localparam int CYCLE_LIMIT = 2_500_000;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  typedef struct {
    status_e          status;
    logic             is_new;
    logic [VAL_W-1:0] value_out;
  } reply_t;

  logic clk;
  logic rst;

  oaht_req_if req_ch ();
  oaht_rsp_if rsp_ch ();
  oaht_cfg_if cfg_ch ();

  open_addressing_hash_table #(
    .CAPACITY(SLOTS),
    .KEY_BITS(KEY_W),
    .VALUE_BITS(VAL_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  mark_e            tbl_mark [SLOTS];
  logic [KEY_W-1:0] tbl_key [SLOTS];
  logic [VAL_W-1:0] tbl_val [SLOTS];
  logic [CNT_W-1:0] tbl_fill;
  logic [CNT_W-1:0] tbl_limit;

  reply_t pending_replies [$];

  logic [KEY_W-1:0]  pool_key [POOL];
  logic [HASH_W-1:0] pool_hash [POOL];
  logic [KEY_W-1:0]  recent_key [RECENT];
  logic [HASH_W-1:0] recent_hash [RECENT];
  int recent_n = 0;

  int errors = 0;
  int cycle_count = 0;
  int n_sent = 0;
  int n_placed = 0;
  int n_ok = 0;
  int n_miss = 0;
  int n_full = 0;
  int n_limits = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int hold_off_req = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[open_addressing_hash_table] ERROR");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic void probe_slots(input logic [KEY_W-1:0] key,
                                      input logic [HASH_W-1:0] hash,
                                      output bit hit, output bit have_slot,
                                      output int unsigned slot);
    int unsigned idx;
    int unsigned tomb;
    bit have_tomb;
    idx = hash & (SLOTS - 1);
    tomb = 0;
    have_tomb = 1'b0;
    hit = 1'b0;
    have_slot = 1'b0;
    slot = 0;
    for (int n = 0; n < SLOTS; n++) begin
      if (tbl_mark[idx] == MARK_EMPTY) begin
        have_slot = 1'b1;
        slot = have_tomb ? tomb : idx;
        return;
      end
      if (tbl_mark[idx] == MARK_TOMB) begin
        if (!have_tomb) begin
          have_tomb = 1'b1;
          tomb = idx;
        end
      end else if (tbl_key[idx] == key) begin
        hit = 1'b1;
        have_slot = 1'b1;
        slot = idx;
        return;
      end
      idx = (idx + 1) & (SLOTS - 1);
    end
    if (have_tomb) begin
      have_slot = 1'b1;
      slot = tomb;
    end
  endfunction

  function automatic reply_t predict_table_op(input logic [CMD_W-1:0] cmd,
                                              input logic [KEY_W-1:0] key,
                                              input logic [HASH_W-1:0] hash,
                                              input logic [VAL_W-1:0] value);
    reply_t r;
    bit hit;
    bit have_slot;
    int unsigned slot;
    r.status = ST_MISS;
    r.is_new = 1'b0;
    r.value_out = '0;
    case (cmd)
      CMD_LOOKUP: begin
        if (tbl_fill != 0) begin
          probe_slots(key, hash, hit, have_slot, slot);
          if (hit) begin
            r.status = ST_OK;
            r.value_out = tbl_val[slot];
          end
        end
      end
      CMD_INSERT: begin
        probe_slots(key, hash, hit, have_slot, slot);
        if (hit) begin
          tbl_val[slot] = value;
          r.status = ST_OK;
        end else if (!have_slot) begin
          r.status = ST_FULL;
        end else if (tbl_mark[slot] == MARK_EMPTY && int'(tbl_fill) + 1 > int'(tbl_limit)) begin
          r.status = ST_FULL;
        end else begin
          if (tbl_mark[slot] == MARK_EMPTY) tbl_fill = tbl_fill + 1'b1;
          tbl_mark[slot] = MARK_LIVE;
          tbl_key[slot] = key;
          tbl_val[slot] = value;
          r.status = ST_OK;
          r.is_new = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (tbl_fill != 0) begin
          probe_slots(key, hash, hit, have_slot, slot);
          if (hit) begin
            tbl_mark[slot] = MARK_TOMB;
            r.status = ST_OK;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] expected,
                                 input logic [63:0] got);
    $display("[%0t] mismatch in %s: expected %0h, got %0h", $time, what, expected, got);
    errors++;
  endtask

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                              input logic [HASH_W-1:0] hash,
                              input logic [VAL_W-1:0] value);
    int unsigned gap;
    reply_t exp;
    gap = tx_burst ? 0 : gap_len();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.command <= cmd;
    req_ch.key <= key;
    req_ch.key_hash <= hash;
    req_ch.new_value <= value;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    exp = predict_table_op(cmd, key, hash, value);
    pending_replies.push_back(exp);
    n_sent++;
    if (exp.is_new) n_placed++;
    else if (exp.status == ST_OK) n_ok++;
    else if (exp.status == ST_FULL) n_full++;
    else n_miss++;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_fill_limit(input logic [CNT_W-1:0] limit);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.fill_limit <= limit;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    tbl_limit = limit;
    n_limits++;
  endtask

  task automatic send_pool_op();
    int k;
    int unsigned r;
    k = $urandom_range(0, POOL - 1);
    r = $urandom_range(0, 99);
    if (r < 45) send_request(CMD_INSERT, pool_key[k], pool_hash[k], rand_value());
    else if (r < 75) send_request(CMD_LOOKUP, pool_key[k], pool_hash[k], rand_value());
    else send_request(CMD_REMOVE, pool_key[k], pool_hash[k], rand_value());
  endtask

  task automatic send_recent_op();
    int k;
    k = $urandom_range(0, RECENT - 1);
    case ($urandom_range(0, 3))
      0: send_request(CMD_LOOKUP, recent_key[k], recent_hash[k], '0);
      1: send_request(CMD_REMOVE, recent_key[k], recent_hash[k], '0);
      2: send_request(CMD_INSERT, recent_key[k], recent_hash[k], rand_value());
      default: send_request(CMD_INSERT, $urandom, $urandom, rand_value());
    endcase
  endtask

  task automatic test_directed_cases();
    set_fill_limit(9'd0);
    send_request(CMD_LOOKUP, '0, '0, '0);
    send_request(CMD_REMOVE, '0, '0, '1);
    send_request(CMD_UNKNOWN, '1, '1, '1);
    send_request(CMD_INSERT, '1, '1, '1);
    set_fill_limit(9'd1);
    send_request(CMD_INSERT, '1, '1, '1);
    send_request(CMD_LOOKUP, '1, '1, '0);
    send_request(CMD_INSERT, '1, '1, '0);
    send_request(CMD_LOOKUP, '1, '1, '1);
    send_request(CMD_INSERT, '0, 32'h0000_00FF, 64'h5555_5555_5555_5555);
    send_request(CMD_REMOVE, '1, '1, '0);
    send_request(CMD_LOOKUP, '1, '1, '0);
    send_request(CMD_REMOVE, '1, '1, '0);
    send_request(CMD_INSERT, '0, 32'h0000_00FF, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(CMD_LOOKUP, '0, 32'h0000_00FF, '0);
    set_fill_limit(CNT_W'(SLOTS));
    send_request(CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 64'h0123_4567_89AB_CDEF);
    send_request(CMD_LOOKUP, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    send_request(CMD_LOOKUP, '1, 32'hFFFF_FF00, '0);
    send_request(CMD_UNKNOWN, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    send_request(CMD_REMOVE, '0, 32'h0000_00FF, '0);
    send_request(CMD_LOOKUP, 32'h8000_0000, 32'h7FFF_FFFF, '0);
  endtask

  task automatic test_mixed_traffic(input int n_items, input logic [CNT_W-1:0] limit);
    int k;
    int unsigned r;
    set_fill_limit(limit);
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      k = $urandom_range(0, POOL - 1);
      if (r < 10) send_request(CMD_W'($urandom_range(0, 3)), $urandom, $urandom, rand_value());
      else if (r < 14) send_request(CMD_UNKNOWN, pool_key[k], pool_hash[k], rand_value());
      else send_pool_op();
    end
    tx_burst = 1'b0;
  endtask

  task automatic test_output_stall();
    tx_burst = 1'b1;
    hold_off_req = 400;
    repeat (40) send_pool_op();
    wait_drained();
    tx_burst = 1'b0;
    repeat (20) send_pool_op();
  endtask

  task automatic test_fill_to_capacity();
    logic [KEY_W-1:0] key;
    logic [HASH_W-1:0] hash;
    set_fill_limit(CNT_W'(SLOTS));
    for (int i = 0; i < 320; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        send_pool_op();
      end else begin
        key = $urandom;
        hash = $urandom;
        send_request(CMD_INSERT, key, hash, rand_value());
        recent_key[recent_n % RECENT] = key;
        recent_hash[recent_n % RECENT] = hash;
        recent_n++;
      end
    end
    repeat (60) send_recent_op();
    set_fill_limit('1);
    repeat (20) send_recent_op();
  endtask

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin : drain_replies
      int hold_left;
      int stall_left;
      int rx_cycles;
      hold_left = 0;
      stall_left = 0;
      rx_cycles = 0;
      forever begin
        @(posedge clk);
        rx_cycles++;
        if (rx_cycles % 256 == 0) rx_burst = ($urandom_range(0, 2) == 0);
        if (hold_off_req > 0) begin
          hold_left = hold_off_req;
          hold_off_req = 0;
        end
        if (hold_left > 0) begin
          rsp_ch.ready <= 1'b0;
          hold_left--;
        end else if (stall_left > 0) begin
          rsp_ch.ready <= 1'b0;
          stall_left--;
        end else begin
          rsp_ch.ready <= 1'b1;
          if (!rx_burst && $urandom_range(0, 2) == 0) stall_left = gap_len();
        end
      end
    end
  end

  always @(posedge clk) begin : check_replies
    reply_t exp;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("response with nothing pending", '0, rsp_ch.status);
      end else begin
        exp = pending_replies.pop_front();
        if (rsp_ch.status !== exp.status) report_mismatch("status", exp.status, rsp_ch.status);
        if (rsp_ch.is_new !== exp.is_new) report_mismatch("is_new", exp.is_new, rsp_ch.is_new);
        if (rsp_ch.value_out !== exp.value_out) begin
          report_mismatch("value_out", exp.value_out, rsp_ch.value_out);
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.command <= CMD_LOOKUP;
    req_ch.key <= '0;
    req_ch.key_hash <= '0;
    req_ch.new_value <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.fill_limit <= FILL_LIMIT_RST;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_mark[i] = MARK_EMPTY;
      tbl_key[i] = '0;
      tbl_val[i] = '0;
    end
    tbl_fill = '0;
    tbl_limit = FILL_LIMIT_RST;
    // Half of the keys crowd into the 32 slots around the wrap point to force long probes.
    for (int i = 0; i < POOL; i++) begin
      pool_key[i] = $urandom;
      pool_hash[i] = $urandom;
      if (i % 2 == 0) pool_hash[i][7:0] = 8'($urandom_range(240, 271));
    end
    pool_key[0] = '0;
    pool_key[1] = '1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_mixed_traffic(250, 9'd24);
    test_mixed_traffic(250, FILL_LIMIT_RST);
    test_output_stall();
    test_mixed_traffic(250, CNT_W'($urandom_range(1, 200)));
    test_mixed_traffic(250, 9'd128);
    test_fill_to_capacity();

    wait_drained();
    repeat (SLOTS + 16) @(posedge clk);
    $display("Ran %0d requests across %0d fill limit settings: %0d keys placed, %0d other hits,",
             n_sent, n_limits, n_placed, n_ok);
    $display("%0d misses and %0d refusals, up to a saturated table; %0d mismatches.",
             n_miss, n_full, errors);
    if (errors == 0) begin
      $display("[open_addressing_hash_table] OK");
    end else begin
      $display("[open_addressing_hash_table] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
design/oaht_pkg.sv
design/oaht_if.sv
design/oaht_ram.sv
design/oaht_ctrl.sv
design/oaht_dp.sv
design/open_addressing_hash_table.sv
dv/tb_open_addressing_hash_table.sv
